@@ hdl/jas_pkg.sv @@
// ----------------------------------------------------------------------------
// jas_pkg: shared types and constants of the adjugate scaler
// Field widths, internal arithmetic widths, register codes and the
// factor table of the 3x3 adjugate cofactor products.
// ----------------------------------------------------------------------------
package jas_pkg;

   // field widths
   localparam int J_W        = 24;
   localparam int WEIGHT_W   = 24;
   localparam int COEF_W     = 32;
   localparam int DIM_W      = 2;
   localparam int OUT_W      = 48;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // internal arithmetic widths
   localparam int CW_W      = WEIGHT_W + 1 + COEF_W;     // signed weight * coefficient
   localparam int CW_MAG_W  = 55;                        // |cw| < 2^55
   localparam int PROD_W    = 2 * J_W;                   // signed Jacobian product
   localparam int ADJ_W     = PROD_W + 1;                // signed cofactor
   localparam int ADJ_MAG_W = PROD_W;                    // |cofactor| <= 2^47
   localparam int SPLIT_X   = 28;                        // low slice of |cw|
   localparam int SPLIT_Y   = 24;                        // low slice of |adj|
   localparam int XH_W      = CW_MAG_W - SPLIT_X;
   localparam int YH_W      = ADJ_MAG_W - SPLIT_Y;
   localparam int FULL_W    = CW_MAG_W + ADJ_MAG_W;      // exact product magnitude
   localparam int SHIFT_2D  = 39 + 20 - 32;
   localparam int SHIFT_3D  = 39 + 40 - 32;
   localparam int RND_W     = FULL_W - SHIFT_2D + 1;     // rounded magnitude

   // pipeline shape
   localparam int N_ENT  = 9;
   localparam int N_PROD = 2 * N_ENT;
   localparam int N_STG  = 6;

   // register codes and reset values
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEFFICIENT = 8'd0,
      REG_DIMENSION   = 8'd1
   } reg_idx_type;

   localparam logic signed [COEF_W-1:0] COEF_RESET = 32'sd65536;
   localparam logic [DIM_W-1:0]         DIM_RESET  = 2'd3;
   localparam logic [DIM_W-1:0]         DIM_2D     = 2'd2;

   // factor pairs of the cofactor products: entry k is product 2k minus product 2k+1
   localparam logic [3:0] PROD_A [N_PROD] = '{
      4'd4, 4'd5, 4'd7, 4'd1, 4'd1, 4'd4, 4'd6, 4'd3, 4'd0,
      4'd2, 4'd3, 4'd0, 4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] PROD_B [N_PROD] = '{
      4'd8, 4'd7, 4'd2, 4'd8, 4'd5, 4'd2, 4'd5, 4'd8, 4'd8,
      4'd6, 4'd2, 4'd5, 4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd3};

   // stage load enables handed to the entry lanes
   typedef struct packed {
      logic b;
      logic c;
      logic d;
      logic e;
      logic f;
   } jas_en_type;

endpackage

@@ hdl/jas_if.sv @@
// ----------------------------------------------------------------------------
// jas channel interfaces
// Request, response and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface jas_req_if;
   import jas_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [J_W-1:0]     j11;
   logic signed [J_W-1:0]     j12;
   logic signed [J_W-1:0]     j13;
   logic signed [J_W-1:0]     j21;
   logic signed [J_W-1:0]     j22;
   logic signed [J_W-1:0]     j23;
   logic signed [J_W-1:0]     j31;
   logic signed [J_W-1:0]     j32;
   logic signed [J_W-1:0]     j33;
   logic [WEIGHT_W-1:0]       weight;
   logic                      last_point;

   modport source (
      output valid, j11, j12, j13, j21, j22, j23, j31, j32, j33, weight, last_point,
      input  ready
   );
   modport sink (
      input  valid, j11, j12, j13, j21, j22, j23, j31, j32, j33, weight, last_point,
      output ready
   );
endinterface

interface jas_rsp_if;
   import jas_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [OUT_W-1:0]   a11;
   logic signed [OUT_W-1:0]   a12;
   logic signed [OUT_W-1:0]   a13;
   logic signed [OUT_W-1:0]   a21;
   logic signed [OUT_W-1:0]   a22;
   logic signed [OUT_W-1:0]   a23;
   logic signed [OUT_W-1:0]   a31;
   logic signed [OUT_W-1:0]   a32;
   logic signed [OUT_W-1:0]   a33;
   logic                      last_out;
   logic                      saturated;

   modport source (
      output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, last_out, saturated,
      input  ready
   );
   modport sink (
      input  valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, last_out, saturated,
      output ready
   );
endinterface

interface jas_csr_if;
   import jas_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_W-1:0]      index;
   logic [CSR_DATA_W-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

@@ hdl/jas_lane.sv @@
// ----------------------------------------------------------------------------
// jas_lane: one adjugate entry through scaling, rounding and saturation
// Takes the signed cofactor and |cw|, forms the exact product from four
// partial products, rounds half away from zero and clamps to 48 bits.
// ----------------------------------------------------------------------------
module jas_lane (
   input  logic                               clock,
   input  jas_pkg::jas_en_type                en,
   input  logic                               dim_2d,
   input  logic signed [jas_pkg::ADJ_W-1:0]   adj,
   input  logic [jas_pkg::CW_MAG_W-1:0]       cw_mag,
   input  logic                               cw_neg,
   output logic signed [jas_pkg::OUT_W-1:0]   value,
   output logic                               sat
);
   import jas_pkg::*;

   localparam logic [RND_W-1:0] LIM_POS = (RND_W'(1) << (OUT_W - 1)) - RND_W'(1);
   localparam logic [RND_W-1:0] LIM_NEG = RND_W'(1) << (OUT_W - 1);

   logic [ADJ_MAG_W-1:0]          adj_mag_ff, adj_mag_in;
   logic                          adj_neg_ff;
   logic [SPLIT_X+SPLIT_Y-1:0]    p00_ff, p00_in, p01_ff, p01_in;
   logic [XH_W+SPLIT_Y-1:0]       p10_ff, p10_in;
   logic [XH_W+YH_W-1:0]          p11_ff, p11_in;
   logic                          neg_c_ff, neg_d_ff, neg_e_ff;
   logic [FULL_W-1:0]             full_ff, full_in;
   logic [RND_W-2:0]              shifted;
   logic                          rnd_bit;
   logic [RND_W-1:0]              mag_ff, mag_in;
   logic [RND_W-1:0]              limit, clamped;
   logic                          over;
   logic signed [OUT_W-1:0]       value_ff, value_in;
   logic                          sat_ff;

   // stage b: cofactor magnitude and sign
   assign adj_mag_in = adj[ADJ_W-1] ? ADJ_MAG_W'(-adj) : ADJ_MAG_W'(adj);

   // stage c: four partial products of |cw| * |adj|
   assign p00_in = cw_mag[SPLIT_X-1:0]        * adj_mag_ff[SPLIT_Y-1:0];
   assign p01_in = cw_mag[SPLIT_X-1:0]        * adj_mag_ff[ADJ_MAG_W-1:SPLIT_Y];
   assign p10_in = cw_mag[CW_MAG_W-1:SPLIT_X] * adj_mag_ff[SPLIT_Y-1:0];
   assign p11_in = cw_mag[CW_MAG_W-1:SPLIT_X] * adj_mag_ff[ADJ_MAG_W-1:SPLIT_Y];

   // stage d: exact product magnitude
   assign full_in = FULL_W'(p00_ff)
                  + (FULL_W'(p01_ff) << SPLIT_Y)
                  + (FULL_W'(p10_ff) << SPLIT_X)
                  + (FULL_W'(p11_ff) << (SPLIT_X + SPLIT_Y));

   // stage e: drop fraction bits, round half away from zero
   always_comb begin
      if (dim_2d) begin
         shifted = full_ff[FULL_W-1:SHIFT_2D];
         rnd_bit = full_ff[SHIFT_2D-1];
      end else begin
         shifted = (RND_W-1)'(full_ff[FULL_W-1:SHIFT_3D]);
         rnd_bit = full_ff[SHIFT_3D-1];
      end
      mag_in = {1'b0, shifted} + RND_W'(rnd_bit);
   end

   // stage f: clamp to the signed range and restore the sign
   always_comb begin
      limit    = neg_e_ff ? LIM_NEG : LIM_POS;
      over     = mag_ff > limit;
      clamped  = over ? limit : mag_ff;
      value_in = neg_e_ff ? -OUT_W'(clamped) : OUT_W'(clamped);
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (en.b) begin
         adj_mag_ff <= adj_mag_in;
         adj_neg_ff <= adj[ADJ_W-1];
      end
      if (en.c) begin
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
         neg_c_ff <= adj_neg_ff ^ cw_neg;
      end
      if (en.d) begin
         full_ff  <= full_in;
         neg_d_ff <= neg_c_ff;
      end
      if (en.e) begin
         mag_ff   <= mag_in;
         neg_e_ff <= neg_d_ff;
      end
      if (en.f) begin
         value_ff <= value_in;
         sat_ff   <= over;
      end
   end

   assign value = value_ff;
   assign sat   = sat_ff;

endmodule

@@ hdl/jacobian_adjugate_scaler.sv @@
// ----------------------------------------------------------------------------
// jacobian_adjugate_scaler: weighted, scaled adjugate of a quadrature Jacobian
// Six register stages, a through f, lie between request accept and response valid.
// Throughput: one request per cycle unless the response is held; each pipeline stage moves on its own
// valid/ready, so bubbles fill while a response is held.
// Reset clears all stage valid bits, sets coefficient to 1.0 and dimension 3.
// ----------------------------------------------------------------------------
module jacobian_adjugate_scaler (
   input  logic      clock,
   input  logic      reset,
   jas_req_if.sink   req_ch,
   jas_rsp_if.source rsp_ch,
   jas_csr_if.sink   csr_ch
);
   import jas_pkg::*;

   // configuration
   logic signed [COEF_W-1:0]   coef_ff;
   logic [DIM_W-1:0]           dim_ff;
   logic                       dim_2d;

   // stage control
   logic [N_STG-1:0]           valid_ff;
   logic [N_STG-1:0]           ready_s;
   logic [N_STG-1:0]           last_ff;
   jas_en_type                 en;

   // stage a: products and weight times coefficient
   logic signed [J_W-1:0]      j_arr [N_ENT];
   logic signed [PROD_W-1:0]   prod_in [N_PROD];
   logic signed [PROD_W-1:0]   prod_ff [N_PROD];
   logic signed [CW_W-1:0]     cw_in, cw_ff;
   logic signed [J_W-1:0]      j11_ff, j12_ff, j21_ff, j22_ff;

   // stage b: cw magnitude, cofactors
   logic [CW_MAG_W-1:0]        cw_mag_ff, cw_mag_in;
   logic                       cw_neg_ff;
   logic signed [ADJ_W-1:0]    adj [N_ENT];

   // lane outputs
   logic signed [OUT_W-1:0]    value [N_ENT];
   logic [N_ENT-1:0]           sat_vec;

   assign dim_2d = (dim_ff == DIM_2D);

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
         dim_ff  <= DIM_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_COEFFICIENT: coef_ff <= csr_ch.data[COEF_W-1:0];
            REG_DIMENSION:   dim_ff  <= csr_ch.data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // per-stage ready: a stage loads when empty or when its content moves on
   always_comb begin
      ready_s[N_STG-1] = !valid_ff[N_STG-1] || rsp_ch.ready;
      for (int k = N_STG - 2; k >= 0; k--) begin
         ready_s[k] = !valid_ff[k] || ready_s[k+1];
      end
   end

   assign en.b = ready_s[1];
   assign en.c = ready_s[2];
   assign en.d = ready_s[3];
   assign en.e = ready_s[4];
   assign en.f = ready_s[5];

   assign req_ch.ready = ready_s[0];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready_s[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < N_STG; k++) begin
            if (ready_s[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // last-point mark alongside
   always_ff @(posedge clock) begin
      if (ready_s[0]) begin
         last_ff[0] <= req_ch.last_point;
      end
      for (int k = 1; k < N_STG; k++) begin
         if (ready_s[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // stage a: Jacobian products and cw
   assign j_arr[0] = req_ch.j11;
   assign j_arr[1] = req_ch.j12;
   assign j_arr[2] = req_ch.j13;
   assign j_arr[3] = req_ch.j21;
   assign j_arr[4] = req_ch.j22;
   assign j_arr[5] = req_ch.j23;
   assign j_arr[6] = req_ch.j31;
   assign j_arr[7] = req_ch.j32;
   assign j_arr[8] = req_ch.j33;

   always_comb begin
      for (int i = 0; i < N_PROD; i++) begin
         prod_in[i] = j_arr[PROD_A[i]] * j_arr[PROD_B[i]];
      end
      cw_in = $signed({1'b0, req_ch.weight}) * coef_ff;
   end

   always_ff @(posedge clock) begin
      if (ready_s[0]) begin
         prod_ff <= prod_in;
         cw_ff   <= cw_in;
         j11_ff  <= req_ch.j11;
         j12_ff  <= req_ch.j12;
         j21_ff  <= req_ch.j21;
         j22_ff  <= req_ch.j22;
      end
   end

   // stage b: cw sign and magnitude
   assign cw_mag_in = cw_ff[CW_W-1] ? CW_MAG_W'(-cw_ff) : CW_MAG_W'(cw_ff);

   always_ff @(posedge clock) begin
      if (ready_s[1]) begin
         cw_mag_ff <= cw_mag_in;
         cw_neg_ff <= cw_ff[CW_W-1];
      end
   end

   // cofactors: 2x2 picks entries directly, 3x3 takes product differences
   always_comb begin
      for (int k = 0; k < N_ENT; k++) begin
         if (dim_2d) begin
            case (k)
               0:       adj[k] = ADJ_W'(j22_ff);
               1:       adj[k] = -ADJ_W'(j12_ff);
               3:       adj[k] = -ADJ_W'(j21_ff);
               4:       adj[k] = ADJ_W'(j11_ff);
               default: adj[k] = '0;
            endcase
         end else begin
            adj[k] = ADJ_W'(prod_ff[2*k]) - ADJ_W'(prod_ff[2*k+1]);
         end
      end
   end

   // entry lanes: stages b through f
   for (genvar g = 0; g < N_ENT; g++) begin : g_lane
      jas_lane u_lane (
         .clock  (clock),
         .en     (en),
         .dim_2d (dim_2d),
         .adj    (adj[g]),
         .cw_mag (cw_mag_ff),
         .cw_neg (cw_neg_ff),
         .value  (value[g]),
         .sat    (sat_vec[g])
      );
   end

   // response
   assign rsp_ch.valid     = valid_ff[N_STG-1];
   assign rsp_ch.a11       = value[0];
   assign rsp_ch.a12       = value[1];
   assign rsp_ch.a13       = value[2];
   assign rsp_ch.a21       = value[3];
   assign rsp_ch.a22       = value[4];
   assign rsp_ch.a23       = value[5];
   assign rsp_ch.a31       = value[6];
   assign rsp_ch.a32       = value[7];
   assign rsp_ch.a33       = value[8];
   assign rsp_ch.last_out  = last_ff[N_STG-1];
   assign rsp_ch.saturated = |sat_vec;

`ifndef SYNTHESIS
   // request side only blocks when every stage holds a request
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff))
      else $error("request blocked while the pipeline has a free stage");

   // an accepted request lands in the first stage with its mark
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=>
         (valid_ff[0] && (last_ff[0] == $past(req_ch.last_point))))
      else $error("accepted request missing from first stage");

   // 2x2 mode leaves the third row and column at zero
   a_zero_2d: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && dim_2d) |->
         ((rsp_ch.a13 == '0) && (rsp_ch.a23 == '0) && (rsp_ch.a31 == '0) &&
          (rsp_ch.a32 == '0) && (rsp_ch.a33 == '0)))
      else $error("nonzero unused entry in 2x2 mode");
`endif

endmodule
